// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the lane assignment RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop on every clock edge outside reset
`define PGILA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that cond never holds outside reset
`define PGILA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hdl/pgila_pkg.sv -----
// Types and status codes for the per-group lane assignment block.
// No dependencies; used by the cell, the top level and the port types.
package pgila_pkg;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_TIMING = 2'd1;
  localparam logic [1:0] ST_LANES  = 2'd2;
  localparam logic [1:0] ST_CUES   = 2'd3;

  typedef struct packed {
    logic [3:0]         group_index;
    logic [15:0]        cue_key;
    logic signed [31:0] cue_start;
    logic signed [31:0] cue_stop;
    logic               last_cue;
  } cue_in_t;

  typedef struct packed {
    logic [5:0] cue_position;
    logic [4:0] lane_number;
    logic [1:0] status;
    logic       last_result;
  } cue_result_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] cue_start;
    logic signed [31:0] cue_stop;
    logic [15:0]        cue_key;
    logic [3:0]         group_index;
    logic [5:0]         pos;
  } cue_entry_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctl_t;

endpackage

// ----- hdl/per_group_interval_lane_assign.sv -----
// Top level: cue loading, sorting chain, first-fit lane search and result emission.
// Depends on pgila_pkg, pgila_cell, pgila_ram and assert_macros.svh.
//
//  channel | dir | handshake                | payload
//  in      | in  | in_valid_i / in_ready_o   | in_item_i (cue_in_t)
//  out     | out | out_valid_o / out_ready_i | out_item_o (cue_result_t)
//  cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_data_i (preroll)
//
// While loading, each cue is placed in order in the cell chain.
// After the last cue: a close state, then per cue a pop state plus a read and a check
// state per lane probed in the lane end RAM, a final pop state, then a read and a load
// state per result emitted.
// Reset clears the control state and the cell chain; no clearing pass is needed.
// A stalled result holds the output register and blocks further progress.
`include "assert_macros.svh"

module per_group_interval_lane_assign #(
  parameter int MAX_CUES        = 64,
  parameter int GROUPS          = 16,
  parameter int LANES_PER_GROUP = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pgila_pkg::cue_in_t     in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output pgila_pkg::cue_result_t out_item_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [30:0]            cfg_data_i
);
  import pgila_pkg::*;

  localparam int PW  = $clog2(MAX_CUES);
  localparam int CNW = $clog2(MAX_CUES + 1);
  localparam int GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int LW  = $clog2(LANES_PER_GROUP + 1);
  localparam int TD  = GROUPS * LANES_PER_GROUP;
  localparam int AW  = (TD > 1) ? $clog2(TD) : 1;

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_CLOSE  = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_LREAD  = 3'd3;
  localparam logic [2:0] S_LCHECK = 3'd4;
  localparam logic [2:0] S_EMRD   = 3'd5;
  localparam logic [2:0] S_EMLD   = 3'd6;
  localparam logic [2:0] S_ERR    = 3'd7;

  function automatic logic [GW-1:0] wrap_group(input logic [3:0] v);
    logic [GW-1:0] r;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      if (v == 4'(k)) r = GW'(k % GROUPS);
    end
    return r;
  endfunction

  logic [2:0]         state_q, state_d;
  logic [30:0]        preroll_q;
  logic [CNW-1:0]     count_q, count_d;
  logic [CNW-1:0]     n_q, n_d;
  logic               bad_q, bad_d;
  logic               many_q, many_d;
  logic [5:0]         first_bad_q, first_bad_d;
  logic [1:0]         err_st_q, err_st_d;
  logic [5:0]         err_pos_q, err_pos_d;
  logic [5:0]         cur_pos_q, cur_pos_d;
  logic [GW-1:0]      cur_grp_q, cur_grp_d;
  logic signed [31:0] cur_end_q, cur_end_d;
  logic signed [31:0] ws_q, ws_d;
  logic [LW-1:0]      lane_q, lane_d;
  logic [CNW-1:0]     emit_q, emit_d;
  logic [LW-1:0]      open_q [GROUPS];
  logic               out_valid_q, out_valid_d;
  cue_result_t        out_q, out_d;

  cell_ctl_t          ctl;
  cue_entry_t         new_entry;
  cue_entry_t         cell_q [MAX_CUES];
  logic               cell_before [MAX_CUES];

  logic               in_acc;
  logic [LW-1:0]      open_cur;
  logic               open_inc, open_clr;
  logic [AW-1:0]      la;
  logic               le_we;
  logic signed [31:0] le_wdata, le_rdata;
  logic               lo_we;
  logic [4:0]         lo_rdata;
  logic signed [32:0] diff;

  assign in_ready_o  = (state_q == S_LOAD);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign open_cur    = open_q[cur_grp_q];
  assign la          = AW'(cur_grp_q) * AW'(LANES_PER_GROUP) + AW'(lane_q);

  assign new_entry.valid       = 1'b1;
  assign new_entry.cue_start   = in_item_i.cue_start;
  assign new_entry.cue_stop    = in_item_i.cue_stop;
  assign new_entry.cue_key     = in_item_i.cue_key;
  assign new_entry.group_index = in_item_i.group_index;
  assign new_entry.pos         = 6'(count_q);

  assign diff = {cell_q[0].cue_start[31], cell_q[0].cue_start} - {2'b00, preroll_q};

  for (genvar i = 0; i < MAX_CUES; i++) begin : g_cell
    cue_entry_t prev_e, next_e;
    logic       prev_b;
    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_b = 1'b0;
    end else begin : g_mid
      assign prev_e = cell_q[i-1];
      assign prev_b = cell_before[i-1];
    end
    if (i == MAX_CUES - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_nxt
      assign next_e = cell_q[i+1];
    end
    pgila_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .new_i         (new_entry),
      .prev_i        (prev_e),
      .prev_before_i (prev_b),
      .next_i        (next_e),
      .held_o        (cell_q[i]),
      .before_o      (cell_before[i])
    );
  end

  pgila_ram #(.WIDTH(32), .DEPTH(TD)) u_lane_end (
    .clk_i   (clk_i),
    .we_i    (le_we),
    .waddr_i (la),
    .wdata_i (le_wdata),
    .raddr_i (la),
    .rdata_o (le_rdata)
  );

  pgila_ram #(.WIDTH(5), .DEPTH(MAX_CUES)) u_lane_of (
    .clk_i   (clk_i),
    .we_i    (lo_we),
    .waddr_i (cur_pos_q[PW-1:0]),
    .wdata_i (5'(lane_q + LW'(1))),
    .raddr_i (emit_q[PW-1:0]),
    .rdata_o (lo_rdata)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n_d         = n_q;
    bad_d       = bad_q;
    many_d      = many_q;
    first_bad_d = first_bad_q;
    err_st_d    = err_st_q;
    err_pos_d   = err_pos_q;
    cur_pos_d   = cur_pos_q;
    cur_grp_d   = cur_grp_q;
    cur_end_d   = cur_end_q;
    ws_d        = ws_q;
    lane_d      = lane_q;
    emit_d      = emit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ctl         = '0;
    open_inc    = 1'b0;
    open_clr    = 1'b0;
    le_we       = 1'b0;
    le_wdata    = cur_end_q;
    lo_we       = 1'b0;

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (count_q < CNW'(MAX_CUES)) begin
            ctl.insert = 1'b1;
            count_d    = count_q + CNW'(1);
            if ((in_item_i.cue_stop < in_item_i.cue_start) && !bad_q) begin
              bad_d       = 1'b1;
              first_bad_d = 6'(count_q);
            end
          end else begin
            many_d = 1'b1;
          end
          if (in_item_i.last_cue) begin
            state_d = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        n_d     = count_q;
        count_d = '0;
        bad_d   = 1'b0;
        many_d  = 1'b0;
        first_bad_d = '0;
        if (many_q) begin
          err_st_d  = ST_CUES;
          err_pos_d = '0;
          state_d   = S_ERR;
        end else if (bad_q) begin
          err_st_d  = ST_TIMING;
          err_pos_d = first_bad_q;
          state_d   = S_ERR;
        end else begin
          open_clr = 1'b1;
          state_d  = S_POP;
        end
      end
      S_POP: begin
        if (cell_q[0].valid) begin
          ctl.shift = 1'b1;
          cur_pos_d = cell_q[0].pos;
          cur_grp_d = wrap_group(cell_q[0].group_index);
          cur_end_d = cell_q[0].cue_stop;
          ws_d      = diff[32] ? 32'sd0 : diff[31:0];
          lane_d    = '0;
          state_d   = S_LREAD;
        end else begin
          emit_d  = '0;
          state_d = S_EMRD;
        end
      end
      S_LREAD: begin
        if (lane_q == open_cur) begin
          if (open_cur == LW'(LANES_PER_GROUP)) begin
            err_st_d  = ST_LANES;
            err_pos_d = cur_pos_q;
            state_d   = S_ERR;
          end else begin
            le_we    = 1'b1;
            le_wdata = cur_end_q;
            lo_we    = 1'b1;
            open_inc = 1'b1;
            state_d  = S_POP;
          end
        end else begin
          state_d = S_LCHECK;
        end
      end
      S_LCHECK: begin
        if (ws_q >= le_rdata) begin
          le_we    = 1'b1;
          le_wdata = (cur_end_q > le_rdata) ? cur_end_q : le_rdata;
          lo_we    = 1'b1;
          state_d  = S_POP;
        end else begin
          lane_d  = lane_q + LW'(1);
          state_d = S_LREAD;
        end
      end
      S_EMRD: begin
        state_d = S_EMLD;
      end
      S_EMLD: begin
        if (!out_valid_q) begin
          out_valid_d           = 1'b1;
          out_d.cue_position    = 6'(emit_q);
          out_d.lane_number     = lo_rdata;
          out_d.status          = ST_OK;
          out_d.last_result     = (emit_q == n_q - CNW'(1));
          if (emit_q == n_q - CNW'(1)) begin
            state_d = S_LOAD;
          end else begin
            emit_d  = emit_q + CNW'(1);
            state_d = S_EMRD;
          end
        end
      end
      S_ERR: begin
        ctl.clear = 1'b1;
        if (!out_valid_q) begin
          out_valid_d        = 1'b1;
          out_d.cue_position = err_pos_q;
          out_d.lane_number  = '0;
          out_d.status       = err_st_q;
          out_d.last_result  = 1'b1;
          state_d            = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      preroll_q   <= '0;
      count_q     <= '0;
      n_q         <= '0;
      bad_q       <= 1'b0;
      many_q      <= 1'b0;
      first_bad_q <= '0;
      err_st_q    <= ST_OK;
      err_pos_q   <= '0;
      emit_q      <= '0;
      lane_q      <= '0;
      out_valid_q <= 1'b0;
      for (int g = 0; g < GROUPS; g++) begin
        open_q[g] <= '0;
      end
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      n_q         <= n_d;
      bad_q       <= bad_d;
      many_q      <= many_d;
      first_bad_q <= first_bad_d;
      err_st_q    <= err_st_d;
      err_pos_q   <= err_pos_d;
      emit_q      <= emit_d;
      lane_q      <= lane_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        preroll_q <= cfg_data_i;
      end
      if (open_clr) begin
        for (int g = 0; g < GROUPS; g++) begin
          open_q[g] <= '0;
        end
      end else if (open_inc) begin
        open_q[cur_grp_q] <= open_cur + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_pos_q <= cur_pos_d;
    cur_grp_q <= cur_grp_d;
    cur_end_q <= cur_end_d;
    ws_q      <= ws_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `PGILA_ASSERT(a_load_src, $rose(out_valid_o) |-> $past(state_q) != S_LOAD, "result from load")
  `PGILA_ASSERT(a_open_rng, state_q == S_LREAD |-> open_cur <= LW'(LANES_PER_GROUP), "lane count")
  `PGILA_NEVER(a_err_lane, out_valid_o && out_item_o.status != ST_OK && out_item_o.lane_number != 5'd0, "lane on error")

endmodule

// ----- hdl/pgila_ram.sv -----
// Generic simple dual-port RAM with registered read.
// No dependencies.
module pgila_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pgila_cell.sv -----
// One cell of the sorting chain: holds one cue, inserts in order, shifts left, clears.
// Depends on pgila_pkg.
module pgila_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pgila_pkg::cell_ctl_t   ctl_i,
  input  pgila_pkg::cue_entry_t  new_i,
  input  pgila_pkg::cue_entry_t  prev_i,
  input  logic                   prev_before_i,
  input  pgila_pkg::cue_entry_t  next_i,
  output pgila_pkg::cue_entry_t  held_o,
  output logic                   before_o
);
  import pgila_pkg::*;

  cue_entry_t held_q, held_d;

  assign before_o = !held_q.valid
                 || ($signed(new_i.cue_start) < $signed(held_q.cue_start))
                 || ((new_i.cue_start == held_q.cue_start)
                     && (new_i.cue_key < held_q.cue_key));

  always_comb begin
    held_d = held_q;
    priority if (ctl_i.clear) begin
      held_d.valid = 1'b0;
    end else if (ctl_i.insert) begin
      if (before_o) begin
        held_d = prev_before_i ? prev_i : new_i;
      end
    end else if (ctl_i.shift) begin
      held_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  assign held_o = held_q;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench for per_group_interval_lane_assign: loads cue sets, predicts
// per-cue lane numbers and error results, and compares each result in order.
// Depends on pgila_pkg and the RTL of the block.
module tb_top;
  import pgila_pkg::*;

  localparam int MAX_CUES    = 64;
  localparam int GROUPS      = 16;
  localparam int LANES       = 16;
  localparam int WDOG_MAX    = 20000;
  localparam int HOLDOFF_LEN = 3000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  cue_in_t     in_item_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  cue_result_t out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [30:0] cfg_data_i;

  per_group_interval_lane_assign dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // predictor state
  logic [30:0]        preroll_q;
  logic signed [31:0] set_start[MAX_CUES];
  logic signed [31:0] set_end[MAX_CUES];
  logic [3:0]         set_group[MAX_CUES];
  logic [15:0]        set_key[MAX_CUES];
  int                 set_count;
  bit                 set_timing_bad;
  int                 set_first_bad;
  bit                 set_overflow;

  cue_result_t expected_results[$];
  int  errors = 0;
  int  idle_pct_in, idle_pct_out;
  int  holdoff_cycles = 0;
  bit  holdoff_req;
  bit  holdoff_taken = 1'b0;
  int  wdog = 0;

  typedef struct {
    cue_in_t     cue;
    bit          checked;
    cue_result_t res;
  } stim_row_t;

  stim_row_t rows[$];

  function automatic bit cue_precedes(int a, int b);
    if (set_start[a] != set_start[b]) return set_start[a] < set_start[b];
    if (set_key[a] != set_key[b]) return set_key[a] < set_key[b];
    return a < b;
  endfunction

  function automatic void push_result(int pos, int lane, logic [1:0] st, bit last);
    cue_result_t r;
    r.cue_position = pos[5:0];
    r.lane_number  = lane[4:0];
    r.status       = st;
    r.last_result  = last;
    expected_results = {expected_results, r};
  endfunction

  function automatic void assign_lanes();
    int order[MAX_CUES];
    int lane_of[MAX_CUES];
    logic signed [31:0] lane_end[GROUPS][LANES];
    int open_cnt[GROUPS];
    longint ws;
    int j, c, g, l;
    if (set_overflow) begin
      push_result(0, 0, ST_CUES, 1'b1);
      return;
    end
    if (set_timing_bad) begin
      push_result(set_first_bad, 0, ST_TIMING, 1'b1);
      return;
    end
    for (int i = 0; i < set_count; i++) begin
      j = i;
      while (j > 0 && cue_precedes(i, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (int k = 0; k < GROUPS; k++) open_cnt[k] = 0;
    for (int i = 0; i < set_count; i++) begin
      c = order[i];
      g = set_group[c];
      ws = longint'(set_start[c]) - longint'(preroll_q);
      if (ws < 0) ws = 0;
      l = 0;
      while (l < open_cnt[g] && ws < longint'(lane_end[g][l])) l++;
      if (l == open_cnt[g]) begin
        if (l >= LANES) begin
          push_result(c, 0, ST_LANES, 1'b1);
          return;
        end
        lane_end[g][l] = set_end[c];
        open_cnt[g] = l + 1;
      end else if (set_end[c] > lane_end[g][l]) begin
        lane_end[g][l] = set_end[c];
      end
      lane_of[c] = l + 1;
    end
    for (int i = 0; i < set_count; i++)
      push_result(i, lane_of[i], ST_OK, i + 1 == set_count);
  endfunction

  function automatic void load_cue(cue_in_t cue);
    if (set_count < MAX_CUES) begin
      set_group[set_count] = cue.group_index;
      set_key[set_count]   = cue.cue_key;
      set_start[set_count] = cue.cue_start;
      set_end[set_count]   = cue.cue_stop;
      if (cue.cue_stop < cue.cue_start && !set_timing_bad) begin
        set_timing_bad = 1'b1;
        set_first_bad  = set_count;
      end
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (cue.last_cue) begin
      assign_lanes();
      set_count = 0;
      set_timing_bad = 1'b0;
      set_first_bad = 0;
      set_overflow = 1'b0;
    end
  endfunction

  // valid stays high after an accept until the next cue, an idle cycle or drain
  task automatic send_cue(cue_in_t cue);
    while (idle_pct_in > 0 && $urandom_range(99) < idle_pct_in) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_item_i  <= cue;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    load_cue(cue);
    @(negedge clk_i);
  endtask

  // directed rows with typed-in results bypass the predictor but keep set state aligned
  task automatic send_cue_unpredicted(cue_in_t cue);
    in_item_i  <= cue;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    set_count = 0; set_timing_bad = 0; set_first_bad = 0; set_overflow = 0;
    @(negedge clk_i);
  endtask

  task automatic write_preroll(logic [30:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    preroll_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  function automatic cue_in_t make_cue(logic [3:0] g, logic [15:0] k,
                                       logic signed [31:0] s, logic signed [31:0] e,
                                       bit last);
    cue_in_t c;
    c.group_index = g; c.cue_key = k; c.cue_start = s; c.cue_stop = e;
    c.last_cue = last;
    return c;
  endfunction

  function automatic void add_row(cue_in_t cue, bit checked, cue_result_t res);
    stim_row_t r;
    r.cue     = cue;
    r.checked = checked;
    r.res     = res;
    rows = {rows, r};
  endfunction

  // sets of random cues; mostly well-formed, some with bad timing or too many lanes
  task automatic send_random_set(int n, int flavor);
    cue_in_t c;
    logic signed [31:0] s, d;
    int gmax;
    gmax = (flavor == 2) ? 0 : $urandom_range(15);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: s = $urandom();
        1: s = $urandom_range(20) << 16;
        default: s = $urandom_range(400000);
      endcase
      d = (flavor == 2) ? 32'sd1000000 : $urandom_range(300000);
      c = make_cue(4'($urandom_range(gmax)), $urandom_range(3) == 0 ? 16'($urandom()) :
                   16'($urandom_range(3)), s, s + d, i == n - 1);
      if (s + d < s) c.cue_stop = 32'sh7fffffff;
      if (flavor == 1 && $urandom_range(3) == 0) c.cue_stop = s - 1;
      if ($urandom_range(30) == 0) begin
        c.cue_start = $urandom(); c.cue_stop = $urandom();
      end
      send_cue(c);
    end
  endtask

  // result checking
  always @(posedge clk_i) begin
    cue_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result %p", out_item_o);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_item_o.cue_position !== exp_r.cue_position) begin
          $error("cue_position exp %0d got %0d", exp_r.cue_position,
                 out_item_o.cue_position);
          errors++;
        end
        if (out_item_o.lane_number !== exp_r.lane_number) begin
          $error("lane_number exp %0d got %0d", exp_r.lane_number,
                 out_item_o.lane_number);
          errors++;
        end
        if (out_item_o.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_item_o.status);
          errors++;
        end
        if (out_item_o.last_result !== exp_r.last_result) begin
          $error("last_result exp %0d got %0d", exp_r.last_result,
                 out_item_o.last_result);
          errors++;
        end
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (holdoff_req && !holdoff_taken) begin
      holdoff_taken  <= 1'b1;
      holdoff_cycles <= HOLDOFF_LEN;
      out_ready_i    <= 1'b0;
    end else if (holdoff_cycles > 0) begin
      holdoff_cycles <= holdoff_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(idle_pct_out > 0 && $urandom_range(99) < idle_pct_out);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || holdoff_cycles > 0)
      wdog <= 0;
    else if (wdog >= WDOG_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end else
      wdog <= wdog + 1;
  end

  initial begin
    stim_row_t row;
    holdoff_req = 1'b0;
    idle_pct_in = 0; idle_pct_out = 0;
    in_valid_i = 1'b0; in_item_i = '0;
    cfg_valid_i = 1'b0; cfg_data_i = '0;
    preroll_q = '0; set_count = 0; set_timing_bad = 0; set_first_bad = 0;
    set_overflow = 0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table: single cue sets with obvious results, then small sets
    add_row(make_cue(4'd0, 16'd0, 32'sd0, 32'sd0, 1), 1'b1,
            cue_result_t'{6'd0, 5'd1, ST_OK, 1'b1});
    add_row(make_cue(4'hf, 16'hffff, 32'sh7fffffff, 32'sh7fffffff, 1), 1'b1,
            cue_result_t'{6'd0, 5'd1, ST_OK, 1'b1});
    add_row(make_cue(4'h5, 16'h1234, 32'sh80000000, 32'sh7fffffff, 1), 1'b1,
            cue_result_t'{6'd0, 5'd1, ST_OK, 1'b1});
    add_row(make_cue(4'h3, 16'd0, 32'sh7fffffff, 32'sh80000000, 1), 1'b1,
            cue_result_t'{6'd0, 5'd0, ST_TIMING, 1'b1});
    add_row(make_cue(4'd1, 16'd2, 32'sd100, 32'sd200, 0), 1'b0, '0);
    add_row(make_cue(4'd1, 16'd1, 32'sd100, 32'sd150, 0), 1'b0, '0);
    add_row(make_cue(4'd1, 16'd1, 32'sd100, 32'sd150, 0), 1'b0, '0);
    add_row(make_cue(4'd1, 16'd0, 32'sd200, 32'sd300, 0), 1'b0, '0);
    add_row(make_cue(4'd2, 16'd0, 32'sd150, 32'sd160, 1), 1'b0, '0);
    add_row(make_cue(4'd0, 16'd0, 32'sd0, 32'sd10, 0), 1'b0, '0);
    add_row(make_cue(4'd0, 16'd0, 32'sd10, 32'sd5, 0), 1'b0, '0);
    add_row(make_cue(4'd0, 16'd0, 32'sd20, 32'sd1, 1), 1'b1,
            cue_result_t'{6'd1, 5'd0, ST_TIMING, 1'b1});
    foreach (rows[i]) begin
      row = rows[i];
      if (row.checked) begin
        expected_results = {expected_results, row.res};
        send_cue_unpredicted(row.cue);
      end else
        send_cue(row.cue);
    end
    drain();

    // lane overflow: 17 overlapping cues in one group
    for (int i = 0; i < 17; i++)
      send_cue(make_cue(4'd7, i[15:0], i * 10, 32'sd100000, i == 16));
    drain();
    // too many cues
    idle_pct_in = 46;
    for (int i = 0; i < 66; i++)
      send_cue(make_cue(4'($urandom()), 16'($urandom()), $urandom(), $urandom(),
                        i == 65));
    drain();

    // random phases with several preroll settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_preroll(31'h7fffffff);
        1: write_preroll(31'd0);
        2: write_preroll(31'd65536);
        default: write_preroll(31'($urandom()));
      endcase
      idle_pct_in  = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 35 : 46) : 0;
      idle_pct_out = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 3 ? 35 : 46) : 0;
      if (ph == 4) holdoff_req = 1'b1;
      for (int s = 0; s < 3; s++)
        send_random_set($urandom_range(3) == 0 ? $urandom_range(20, 48) :
                        $urandom_range(1, 10),
                        $urandom_range(7) == 0 ? 1 : ($urandom_range(9) == 0 ? 2 : 0));
      drain();
    end

    idle_pct_out = 0;
    drain();
    if (errors == 0 && expected_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- per_group_interval_lane_assign.f -----
+incdir+hdl
hdl/pgila_pkg.sv
hdl/pgila_ram.sv
hdl/pgila_cell.sv
hdl/per_group_interval_lane_assign.sv
verif/tb_top.sv
